// ----- design/mck_pkg.sv -----
// shared types, constants and the letter code table of the morse keyer
// no dependencies
package mck_pkg;

  localparam int CHAR_W  = 8;
  localparam int TICK_W  = 16;
  localparam int GAP_W   = 4;
  localparam int CODE_W  = 4;
  localparam int ELEM_W  = 3;
  localparam int UNITS_W = 4;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_UNIT_TICKS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_GAP_UNITS  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SPACE_TONE = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h7a;

  localparam logic [UNITS_W-1:0] DOT_UNITS   = 4'd1;
  localparam logic [UNITS_W-1:0] DASH_UNITS  = 4'd3;
  localparam logic [UNITS_W-1:0] SPACE_UNITS = 4'd7;

  typedef struct packed {
    logic [TICK_W-1:0] unit_ticks;
    logic [GAP_W-1:0]  gap_units;
    logic              space_tone;
  } mck_cfg_t;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] character;
  } mck_item_t;

  typedef struct packed {
    logic buzzer;
    logic busy_res;
    logic done_res;
    logic rejected;
  } mck_res_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ELEM_W-1:0] len;
  } mck_letter_t;

  // code bits (1 = dash) and element count, index 0 is letter a
  localparam mck_letter_t LETTER_TBL [26] = '{
    '{4'h1, 3'd2}, '{4'h8, 3'd4}, '{4'hA, 3'd4}, '{4'h4, 3'd3}, '{4'h0, 3'd1},
    '{4'h2, 3'd4}, '{4'h6, 3'd3}, '{4'h0, 3'd4}, '{4'h0, 3'd2}, '{4'h7, 3'd4},
    '{4'h5, 3'd3}, '{4'h4, 3'd4}, '{4'h3, 3'd2}, '{4'h2, 3'd2}, '{4'h7, 3'd3},
    '{4'h6, 3'd4}, '{4'hD, 3'd4}, '{4'h2, 3'd3}, '{4'h0, 3'd3}, '{4'h1, 3'd1},
    '{4'h1, 3'd3}, '{4'h1, 3'd4}, '{4'h3, 3'd3}, '{4'h9, 3'd4}, '{4'hB, 3'd4},
    '{4'hC, 3'd4}
  };

endpackage

// ----- design/mck_in_if.sv -----
// input channel of the morse keyer: tick or character load
// depends on mck_pkg
interface mck_in_if import mck_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output op, output character, input ready);
  modport sink   (input valid, input op, input character, output ready);
endinterface

// ----- design/mck_out_if.sv -----
// result channel of the morse keyer
// no dependencies
interface mck_out_if;
  logic valid;
  logic ready;
  logic buzzer;
  logic busy_res;
  logic done_res;
  logic rejected;

  modport source (output valid, output buzzer, output busy_res, output done_res,
                  output rejected, input ready);
  modport sink   (input valid, input buzzer, input busy_res, input done_res,
                  input rejected, output ready);
endinterface

// ----- design/mck_cfg_if.sv -----
// configuration write channel of the morse keyer
// depends on mck_pkg
interface mck_cfg_if import mck_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/morse_character_keyer_core.sv -----
// top level of the morse keyer: input register, sequencer, result register
// depends on mck_pkg, mck_in_if, mck_out_if, mck_cfg_if, mck_cfg_regs, mck_sequencer
//
// in_chan carries one transaction per item: op 0 is one time tick, op 1 loads
// a character. every item gives exactly one transaction on out_chan with the
// buzzer level, busy flag, done flag on the tick that ends the last gap, and a
// rejected flag for a load that arrives while a character is still playing.
// cfg_chan writes unit_ticks (index 0), gap_units (1) and space_tone (2); it
// is always ready, other indexes are dropped. write it only while idle.
// a result passes through the input register and then, through the sequencer,
// into the result register. one item is taken every cycle while out_chan does
// not stall; the sequencer state updates in the same cycle as the result register.
// when out_chan stalls, the result and the input register both hold and
// in_chan drops ready once both are full; nothing is lost.
// reset (rst_n low, synchronous) empties both registers, puts the sequencer
// in idle and restores unit_ticks 1, gap_units 3, space_tone 1.
module morse_character_keyer_core import mck_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mck_in_if.sink    in_chan,
  mck_out_if.source out_chan,
  mck_cfg_if.sink   cfg_chan
);

  mck_cfg_t  cfg;
  mck_item_t s1_item_r;
  logic      s1_valid_r;
  mck_res_t  res;
  mck_res_t  out_res_r;
  logic      out_valid_r;
  logic      out_free;
  logic      adv;
  logic      in_ready;

  assign out_free = !out_valid_r || out_chan.ready;
  assign adv      = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || adv;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  mck_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  mck_sequencer u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      s1_item_r.op        <= in_chan.op;
      s1_item_r.character <= in_chan.character;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.buzzer   = out_res_r.buzzer;
  assign out_chan.busy_res = out_res_r.busy_res;
  assign out_chan.done_res = out_res_r.done_res;
  assign out_chan.rejected = out_res_r.rejected;

endmodule

// ----- design/mck_cfg_regs.sv -----
// configuration registers of the morse keyer
// depends on mck_pkg
module mck_cfg_regs import mck_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CIDX_W-1:0]  wr_index,
  input  logic [CDATA_W-1:0] wr_data,
  output mck_cfg_t           cfg
);

  mck_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_ticks <= TICK_W'(1);
      cfg_r.gap_units  <= GAP_W'(3);
      cfg_r.space_tone <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_UNIT_TICKS: cfg_r.unit_ticks <= wr_data[TICK_W-1:0];
        CFG_GAP_UNITS:  cfg_r.gap_units  <= wr_data[GAP_W-1:0];
        CFG_SPACE_TONE: cfg_r.space_tone <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/mck_sequencer.sv -----
// element sequencer: phase, unit and tick counters, letter lookup
// depends on mck_pkg
module mck_sequencer import mck_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  mck_item_t item,
  input  mck_cfg_t  cfg,
  output mck_res_t  res
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_GAP   = 2'd2,
    PH_SPACE = 2'd3
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [ELEM_W-1:0]  elem_r, elem_nxt;
  logic [UNITS_W-1:0] units_r, units_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;

  mck_letter_t        letter;
  logic [ELEM_W-1:0]  elem_dec;
  logic [TICK_W-1:0]  limit;
  logic [TICK_W-1:0]  tick_inc;
  logic [UNITS_W-1:0] units_dec;
  logic               done;
  logic               rej;

  function automatic logic [UNITS_W-1:0] elem_units(logic [CODE_W-1:0] code,
                                                    logic [ELEM_W-1:0] idx);
    return code[idx[1:0]] ? DASH_UNITS : DOT_UNITS;
  endfunction

  always_comb begin
    if (item.character >= CHAR_A && item.character <= CHAR_Z) begin
      letter = LETTER_TBL[5'(item.character - CHAR_A)];
    end else begin
      letter.code = '0;
      letter.len  = ELEM_W'(1);
    end
  end

  assign limit     = (cfg.unit_ticks == '0) ? TICK_W'(1) : cfg.unit_ticks;
  assign tick_inc  = tick_r + TICK_W'(1);
  assign units_dec = units_r - UNITS_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    code_nxt  = code_r;
    elem_nxt  = elem_r;
    units_nxt = units_r;
    tick_nxt  = tick_r;
    done      = 1'b0;
    rej       = 1'b0;
    elem_dec  = elem_r - ELEM_W'(1);
    if (item.op == OP_LOAD) begin
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else if (item.character == CHAR_SPACE) begin
        code_nxt  = '0;
        elem_nxt  = '0;
        phase_nxt = PH_SPACE;
        units_nxt = SPACE_UNITS;
        tick_nxt  = '0;
      end else begin
        elem_dec  = letter.len - ELEM_W'(1);
        code_nxt  = letter.code;
        elem_nxt  = elem_dec;
        phase_nxt = PH_MARK;
        units_nxt = elem_units(letter.code, elem_dec);
        tick_nxt  = '0;
      end
    end else if (phase_r != PH_IDLE) begin
      if (tick_inc >= limit) begin
        tick_nxt  = '0;
        units_nxt = units_dec;
        if (units_dec == '0) begin
          if (phase_r == PH_GAP) begin
            if (elem_r != '0) begin
              elem_nxt  = elem_dec;
              phase_nxt = PH_MARK;
              units_nxt = elem_units(code_r, elem_dec);
            end else begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          end else begin
            phase_nxt = PH_GAP;
            units_nxt = (cfg.gap_units == '0) ? UNITS_W'(1) : cfg.gap_units;
          end
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      code_r  <= '0;
      elem_r  <= '0;
      units_r <= '0;
      tick_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      elem_r  <= elem_nxt;
      units_r <= units_nxt;
      tick_r  <= tick_nxt;
    end
  end

  always_comb begin
    unique case (phase_nxt)
      PH_MARK:  res.buzzer = 1'b1;
      PH_SPACE: res.buzzer = cfg.space_tone;
      default:  res.buzzer = 1'b0;
    endcase
    res.busy_res = (phase_nxt != PH_IDLE);
    res.done_res = done;
    res.rejected = rej;
  end

endmodule

// ----- sim/tb_morse_character_keyer_core.sv -----
// self-checking testbench for morse_character_keyer_core: random-gap driver, stalled receiver
// and a monitor with a cycle-free keyer predictor that tracks every input transaction
// depends on mck_pkg, mck_in_if, mck_out_if, mck_cfg_if and the design files
module tb_morse_character_keyer_core;
  import mck_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [CODE_W-1:0] MORSE_CODE [26] = '{
    4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
    4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
  };
  localparam logic [ELEM_W-1:0] MORSE_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  typedef enum logic [1:0] {KP_IDLE, KP_MARK, KP_GAP, KP_SPACE} key_phase_t;

  logic clk;
  logic rst_n;

  mck_in_if  in_chan ();
  mck_out_if out_chan ();
  mck_cfg_if cfg_chan ();

  morse_character_keyer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // shadow registers and keyer state
  logic [TICK_W-1:0]  cfg_ut;
  logic [GAP_W-1:0]   cfg_gap;
  logic               cfg_tone;
  logic [CODE_W-1:0]  kp_code;
  logic [ELEM_W-1:0]  kp_elems;
  key_phase_t         kp_phase;
  logic [UNITS_W-1:0] kp_units;
  logic [TICK_W-1:0]  kp_ticks;

  mck_item_t send_q [$];
  mck_res_t  key_out_q [$];

  logic in_taken;
  int   gap_left;
  int   burst_left;
  int   rx_cyc;
  int   rx_mode;
  int   idle_cyc;
  int   fail_cnt;
  int   n_items;
  int   n_results;
  int   n_done;
  int   n_rej;
  int   n_cfg;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void begin_element();
    kp_elems = kp_elems - ELEM_W'(1);
    kp_units = kp_code[kp_elems[1:0]] ? DASH_UNITS : DOT_UNITS;
    kp_phase = KP_MARK;
    kp_ticks = '0;
  endfunction

  function automatic mck_res_t step_keyer(input logic op, input logic [CHAR_W-1:0] ch);
    mck_res_t          r;
    logic [TICK_W-1:0] lim;
    r = '0;
    if (op == OP_LOAD) begin
      if (kp_phase != KP_IDLE) begin
        r.rejected = 1'b1;
      end else if (ch == CHAR_SPACE) begin
        kp_code  = '0;
        kp_elems = '0;
        kp_phase = KP_SPACE;
        kp_units = SPACE_UNITS;
        kp_ticks = '0;
      end else begin
        if (ch >= CHAR_A && ch <= CHAR_Z) begin
          kp_code  = MORSE_CODE[ch - CHAR_A];
          kp_elems = MORSE_LEN[ch - CHAR_A];
        end else begin
          kp_code  = '0;
          kp_elems = 3'd1;
        end
        begin_element();
      end
    end else if (kp_phase != KP_IDLE) begin
      lim = (cfg_ut == '0) ? 16'd1 : cfg_ut;
      kp_ticks = kp_ticks + TICK_W'(1);
      if (kp_ticks >= lim) begin
        kp_ticks = '0;
        kp_units = kp_units - UNITS_W'(1);
        if (kp_units == '0) begin
          if (kp_phase == KP_GAP) begin
            if (kp_elems != '0) begin
              begin_element();
            end else begin
              kp_phase   = KP_IDLE;
              r.done_res = 1'b1;
            end
          end else begin
            kp_phase = KP_GAP;
            kp_units = (cfg_gap == '0) ? 4'd1 : cfg_gap;
          end
        end
      end
    end
    r.buzzer   = (kp_phase == KP_MARK) || (kp_phase == KP_SPACE && cfg_tone);
    r.busy_res = (kp_phase != KP_IDLE);
    return r;
  endfunction

  // ticks needed to play one character from idle back to idle
  function automatic int char_ticks(input logic [CHAR_W-1:0] ch);
    int ut;
    int g;
    int units;
    int n;
    logic [CODE_W-1:0] code;
    ut    = (cfg_ut == '0) ? 1 : int'(cfg_ut);
    g     = (cfg_gap == '0) ? 1 : int'(cfg_gap);
    units = 0;
    if (ch == CHAR_SPACE) begin
      units = 7 + g;
    end else if (ch >= CHAR_A && ch <= CHAR_Z) begin
      code = MORSE_CODE[ch - CHAR_A];
      n    = int'(MORSE_LEN[ch - CHAR_A]);
      for (int i = n - 1; i >= 0; i--) units += (code[i] ? 3 : 1) + g;
    end else begin
      units = 1 + g;
    end
    return units * ut;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CHAR_A + CHAR_W'($urandom_range(0, 25));
    if (r < 85) return CHAR_SPACE;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic queue_item(input logic op, input logic [CHAR_W-1:0] ch);
    mck_item_t it;
    it.op        = op;
    it.character = ch;
    send_q.push_back(it);
  endtask

  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) queue_item(OP_TICK, CHAR_W'($urandom_range(0, 255)));
  endtask

  task automatic wait_empty();
    do @(negedge clk);
    while (send_q.size() != 0 || in_chan.valid || key_out_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // drain, then tick until the character in progress has finished
  task automatic settle();
    wait_empty();
    while (kp_phase != KP_IDLE) begin
      queue_ticks((cfg_ut > 16'd255) ? 4096 : 16);
      wait_empty();
    end
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    case (idx)
      CFG_UNIT_TICKS: cfg_ut   = data;
      CFG_GAP_UNITS:  cfg_gap  = data[GAP_W-1:0];
      CFG_SPACE_TONE: cfg_tone = data[0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [TICK_W-1:0] ut, input logic [GAP_W-1:0] gap,
                               input logic tone);
    logic [CDATA_W-1:0] rnd;
    rnd = CDATA_W'($urandom);
    cfg_write(CFG_UNIT_TICKS, ut);
    cfg_write(CFG_GAP_UNITS, {rnd[15:4], gap});
    rnd = CDATA_W'($urandom);
    cfg_write(CFG_SPACE_TONE, {rnd[15:1], tone});
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_UNUSED, CDATA_W'($urandom));
  endtask

  task automatic random_phase(input int budget);
    int n;
    int t;
    int mid;
    logic [CHAR_W-1:0] ch;
    n = 0;
    while (n < budget) begin
      if ($urandom_range(0, 99) < 80) begin
        ch = pick_char();
        queue_item(OP_LOAD, ch);
        t = char_ticks(ch) + $urandom_range(0, 6) - 3;
        if (t < 0) t = 0;
        mid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, t) : -1;
        for (int i = 0; i < t; i++) begin
          if (i == mid) queue_item(OP_LOAD, pick_char());
          queue_item(OP_TICK, CHAR_W'($urandom_range(0, 255)));
        end
        n += 1 + t;
      end else begin
        queue_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)));
        n++;
      end
    end
  endtask

  // driver and receiver stall pattern
  always @(negedge clk) begin : drive
    mck_item_t nxt;
    if (rst_n && (!in_chan.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (send_q.size() > 0) begin
        nxt = send_q.pop_front();
        in_chan.valid     <= 1'b1;
        in_chan.op        <= nxt.op;
        in_chan.character <= nxt.character;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
    rx_cyc++;
    if (rx_cyc % 200 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       out_chan.ready <= 1'b1;
      1:       out_chan.ready <= ($urandom_range(0, 3) != 0);
      2:       out_chan.ready <= ((rx_cyc % 7) < 4);
      default: out_chan.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // transaction monitor, result check and watchdog
  always @(posedge clk) begin : monitor
    mck_res_t want;
    logic     out_fire;
    in_taken = rst_n && in_chan.valid && in_chan.ready;
    out_fire = rst_n && out_chan.valid && out_chan.ready;
    if (in_taken) begin
      key_out_q.push_back(step_keyer(in_chan.op, in_chan.character));
      n_items++;
    end
    if (out_fire) begin
      n_results++;
      if (out_chan.done_res) n_done++;
      if (out_chan.rejected) n_rej++;
      if (key_out_q.size() == 0) begin
        $error("result transaction with no expected result waiting");
        fail_cnt++;
      end else begin
        want = key_out_q.pop_front();
        if (out_chan.buzzer !== want.buzzer) begin
          $error("buzzer: expected %0b, got %0b", want.buzzer, out_chan.buzzer);
          fail_cnt++;
        end
        if (out_chan.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0b, got %0b", want.busy_res, out_chan.busy_res);
          fail_cnt++;
        end
        if (out_chan.done_res !== want.done_res) begin
          $error("done_res: expected %0b, got %0b", want.done_res, out_chan.done_res);
          fail_cnt++;
        end
        if (out_chan.rejected !== want.rejected) begin
          $error("rejected: expected %0b, got %0b", want.rejected, out_chan.rejected);
          fail_cnt++;
        end
      end
    end
    if (in_taken || out_fire || (cfg_chan.valid && cfg_chan.ready)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("** morse_character_keyer_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.op        = OP_TICK;
    in_chan.character = '0;
    out_chan.ready    = 1'b0;
    cfg_chan.valid    = 1'b0;
    cfg_chan.index    = CFG_UNIT_TICKS;
    cfg_chan.data     = '0;
    in_taken   = 1'b0;
    gap_left   = 0;
    burst_left = 1;
    rx_cyc     = 0;
    rx_mode    = 0;
    idle_cyc   = 0;
    fail_cnt   = 0;
    n_items    = 0;
    n_results  = 0;
    n_done     = 0;
    n_rej      = 0;
    n_cfg      = 0;
    cfg_ut     = 16'd1;
    cfg_gap    = 4'd3;
    cfg_tone   = 1'b1;
    kp_code    = '0;
    kp_elems   = '0;
    kp_phase   = KP_IDLE;
    kp_units   = '0;
    kp_ticks   = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: idle tick, busy load, odd characters, dash, sounded space
    queue_item(OP_TICK, 8'h00);
    settle();
    apply_setting(16'd1, 4'd1, 1'b1);
    queue_item(OP_LOAD, 8'h65);
    queue_item(OP_LOAD, CHAR_A);
    queue_ticks(2);
    queue_item(OP_LOAD, 8'hff);
    queue_ticks(2);
    queue_item(OP_LOAD, 8'h74);
    queue_ticks(4);
    queue_item(OP_LOAD, CHAR_SPACE);
    queue_ticks(8);
    settle();

    // zero unit_ticks and zero gap_units, silent space
    apply_setting(16'd0, 4'd0, 1'b0);
    queue_item(OP_LOAD, CHAR_SPACE);
    queue_ticks(8);
    settle();

    // every letter back to back
    apply_setting(16'd1, 4'd1, 1'($urandom_range(0, 1)));
    for (int i = 0; i < 26; i++) begin
      queue_item(OP_LOAD, CHAR_A + CHAR_W'(i));
      queue_ticks(char_ticks(CHAR_A + CHAR_W'(i)));
    end
    settle();

    apply_setting(16'd1, 4'd3, 1'b1);
    random_phase(15);
    settle();
    apply_setting(16'd1, 4'd1, 1'b0);
    random_phase(15);
    settle();
    apply_setting(16'd2, 4'd2, 1'b1);
    random_phase(15);
    settle();
    apply_setting(16'd1, 4'd15, 1'b0);
    random_phase(20);
    settle();
    apply_setting(16'd3, 4'd1, 1'b1);
    random_phase(15);
    settle();
    apply_setting(16'd4, 4'd7, 1'b0);
    random_phase(10);
    settle();
    apply_setting(16'd0, 4'd0, 1'b1);
    random_phase(15);
    settle();
    for (int p = 0; p < 3; p++) begin
      apply_setting(TICK_W'($urandom_range(1, 3)), GAP_W'($urandom_range(1, 15)),
                    1'($urandom_range(0, 1)));
      random_phase(10);
      settle();
    end

    // longest unit: one dot, with noise while it plays
    apply_setting(16'hffff, 4'd1, 1'b0);
    queue_item(OP_LOAD, 8'h65);
    for (int i = 0; i < 8; i++) begin
      queue_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)));
    end

    wait_empty();
    repeat (10) @(negedge clk);
    if (key_out_q.size() != 0) begin
      $error("%0d expected results never arrived", key_out_q.size());
      fail_cnt++;
    end

    $display("covered %0d input transactions, %0d results, %0d register writes",
             n_items, n_results, n_cfg);
    $display("characters completed %0d, loads rejected while busy %0d", n_done, n_rej);
    if (fail_cnt == 0) begin
      $display("** morse_character_keyer_core: PASSED **");
    end else begin
      $display("** morse_character_keyer_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- morse_character_keyer_core.f -----
design/mck_pkg.sv
design/mck_in_if.sv
design/mck_out_if.sv
design/mck_cfg_if.sv
design/mck_cfg_regs.sv
design/mck_sequencer.sv
design/morse_character_keyer_core.sv
sim/tb_morse_character_keyer_core.sv
